// File: rtl/voice_slot_allocator_top_macros.svh
// Assertion macros used by the voice slot allocator top level.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define VSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voice slot allocator check failed");
// Next-cycle implication, disabled during reset.
`define VSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voice slot allocator check failed");
`else
`define VSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/vsa_pkg.sv
// Package with the types, constants and helpers of the voice slot allocator.
package vsa_pkg;

  localparam int VOICES      = 32;
  localparam int BUFFER_BITS = 16;
  localparam int SLOT_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int BUF_W       = (BUFFER_BITS < 16) ? BUFFER_BITS : 16;
  localparam int MASK_W      = (VOICES < 32) ? VOICES : 32;

  // Item kinds.
  localparam logic [1:0] KIND_PLAY  = 2'd0;
  localparam logic [1:0] KIND_PAUSE = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_MISS   = 3'd0;
  localparam logic [2:0] ACT_CLAIM  = 3'd1;
  localparam logic [2:0] ACT_REPLAY = 3'd2;
  localparam logic [2:0] ACT_PAUSE  = 3'd3;
  localparam logic [2:0] ACT_STOP   = 3'd4;
  localparam logic [2:0] ACT_SWEEP  = 3'd5;

  // Outcome of the slot pick.
  localparam logic [1:0] MODE_MISS       = 2'd0;
  localparam logic [1:0] MODE_HIT        = 2'd1;
  localparam logic [1:0] MODE_CLAIM_RSV  = 2'd2;
  localparam logic [1:0] MODE_CLAIM_FREE = 2'd3;

  // Configuration register indexes.
  localparam logic REG_SWEEP_INTERVAL = 1'b0;
  localparam logic REG_IDLE_TIMEOUT   = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        buffer_id;
    logic               loop_flag;
    logic               reserved_flag;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } vsa_in_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         slot;
    logic               slot_loop;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [31:0]        released_mask;
  } vsa_out_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic [BUF_W-1:0] buf_id;
    logic             loop_flag;
    logic             reserved_flag;
    logic [31:0]      now;
    logic [31:0]      limit;
  } vsa_cmd_t;

  // Write-back controls for the cells.
  typedef struct packed {
    logic en;
    logic refresh;
    logic claim;
    logic set_rsv;
    logic detach;
    logic sweep;
  } vsa_wr_t;

  // Status that one cell reports.
  typedef struct packed {
    logic hit;
    logic attached;
    logic reserved;
    logic looping;
    logic stale;
  } vsa_cell_st_t;

  // Index of the set bit of a one-hot vector.
  function automatic logic [SLOT_W-1:0] onehot_index(input logic [VOICES-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/vsa_cell.sv
// One voice slot cell: holds the slot state and matches it against a command.
module vsa_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rsv_init,
  input  vsa_pkg::vsa_cmd_t     cmd,
  input  vsa_pkg::vsa_wr_t      wr,
  input  logic                  sel,
  output vsa_pkg::vsa_cell_st_t st
);
  import vsa_pkg::*;

  logic             attached_r, attached_nxt;
  logic             reserved_r, reserved_nxt;
  logic             looping_r, looping_nxt;
  logic [BUF_W-1:0] buffer_r, buffer_nxt;
  logic [31:0]      last_use_r, last_use_nxt;

  // Status seen by the pick logic.
  assign st.hit      = attached_r && (buffer_r == cmd.buf_id);
  assign st.attached = attached_r;
  assign st.reserved = reserved_r;
  assign st.looping  = looping_r;
  assign st.stale    = !reserved_r && (cmd.limit > last_use_r);

  // Next slot state for the write-back cycle.
  always_comb begin
    attached_nxt = attached_r;
    reserved_nxt = reserved_r;
    looping_nxt  = looping_r;
    buffer_nxt   = buffer_r;
    last_use_nxt = last_use_r;
    if (wr.en) begin
      if (sel && wr.refresh) begin
        last_use_nxt = cmd.now;
      end
      if (sel && wr.claim) begin
        attached_nxt = 1'b1;
        looping_nxt  = cmd.loop_flag;
        buffer_nxt   = cmd.buf_id;
        last_use_nxt = cmd.now;
        if (wr.set_rsv) begin
          reserved_nxt = cmd.reserved_flag;
        end
      end
      if (sel && wr.detach && !reserved_r) begin
        attached_nxt = 1'b0;
      end
      if (wr.sweep && st.stale) begin
        attached_nxt = 1'b0;
      end
    end
  end

  // Flags are control state; buffer, loop and time are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      reserved_r <= rsv_init;
    end else begin
      attached_r <= attached_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    looping_r  <= looping_nxt;
    buffer_r   <= buffer_nxt;
    last_use_r <= last_use_nxt;
  end

endmodule

// File: rtl/vsa_pick.sv
// Slot pick: chooses the candidate row and isolates its lowest slot.
module vsa_pick (
  input  logic [1:0]                  kind,
  input  logic                        buf_zero,
  input  logic [vsa_pkg::VOICES-1:0]  hit,
  input  logic [vsa_pkg::VOICES-1:0]  resv,
  input  logic [vsa_pkg::VOICES-1:0]  free,
  output logic [vsa_pkg::VOICES-1:0]  onehot,
  output logic [1:0]                  mode
);
  import vsa_pkg::*;

  logic [VOICES-1:0] cand;

  // Candidate row: match; play also reserved (buffer 0), then free.
  always_comb begin
    cand = '0;
    mode = MODE_MISS;
    unique case (kind)
      KIND_PLAY: begin
        if (|hit) begin
          cand = hit;
          mode = MODE_HIT;
        end else if (buf_zero && (|resv)) begin
          cand = resv;
          mode = MODE_CLAIM_RSV;
        end else if (|free) begin
          cand = free;
          mode = MODE_CLAIM_FREE;
        end
      end
      KIND_PAUSE, KIND_STOP: begin
        if (|hit) begin
          cand = hit;
          mode = MODE_HIT;
        end
      end
      default: begin
        cand = '0;
        mode = MODE_MISS;
      end
    endcase
  end

  // Lowest set bit through a two's complement isolate.
  assign onehot = cand & (~cand + VOICES'(1));

endmodule

// File: rtl/voice_slot_allocator_top.sv
// Voice slot allocator top level: command sequencer, row of slot cells, result word.
// Acceptance starts match, pick and write-back in turn; out_valid is registered from write-back.
// A new word is accepted only when idle, so one command is in flight at a time.
// busy is high from the accepting edge until the result cycle begins.
// Reset clears all slots except slot 0, which comes up reserved; registers return
// to interval 2 and timeout 2. The receiver cannot stall the result.
`include "voice_slot_allocator_top_macros.svh"
module voice_slot_allocator_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  vsa_pkg::vsa_in_t in_data,
  output logic             out_valid,
  output vsa_pkg::vsa_out_t out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);
  import vsa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_PICK  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]        state_r, state_nxt;
  vsa_in_t           cmd_r;
  logic [31:0]       limit_r;
  logic [31:0]       seconds_r;
  logic [7:0]        tick_r;
  logic [7:0]        sweep_interval_r;
  logic [7:0]        idle_timeout_r;
  logic [VOICES-1:0] hit_r, resv_r, free_r, stale_r, att_r;
  logic [VOICES-1:0] sel_r;
  logic [1:0]        mode_r;
  logic              out_valid_r;
  vsa_out_t          out_r, out_nxt;

  vsa_cmd_t          cell_cmd;
  vsa_wr_t           wr;
  vsa_cell_st_t      cell_st [VOICES];
  logic [VOICES-1:0] hit_v, resv_v, att_v, loop_v, stale_v;
  logic [VOICES-1:0] pick_oh;
  logic [1:0]        pick_mode;
  logic              accept;
  logic [7:0]        tick_inc;
  logic              sweep_now;
  logic [SLOT_W-1:0] sel_idx;
  logic [VOICES-1:0] stop_rel;
  logic [VOICES-1:0] sweep_rel;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign tick_inc  = tick_r + 8'd1;
  assign sweep_now = (tick_inc == sweep_interval_r);
  assign sel_idx   = onehot_index(sel_r);
  assign stop_rel  = sel_r & ~resv_r;
  assign sweep_rel = stale_r & att_r;

  // Sequencer: match, pick, write-back.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_PICK;
      ST_PICK:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      seconds_r        <= '0;
      tick_r           <= '0;
      sweep_interval_r <= 8'd2;
      idle_timeout_r   <= 8'd2;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_APPLY);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SWEEP_INTERVAL: sweep_interval_r <= cfg_data;
          REG_IDLE_TIMEOUT:   idle_timeout_r   <= cfg_data;
          default:            sweep_interval_r <= sweep_interval_r;
        endcase
      end
      if ((state_r == ST_APPLY) && (cmd_r.kind == KIND_TICK)) begin
        seconds_r <= seconds_r + 32'd1;
        tick_r    <= sweep_now ? 8'd0 : tick_inc;
      end
    end
  end

  // Command word and the sweep limit for the coming second.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data;
      limit_r <= seconds_r + 32'd1 - {24'd0, idle_timeout_r};
    end
  end

  // Broadcast to the row of cells.
  assign cell_cmd.buf_id        = cmd_r.buffer_id[BUF_W-1:0];
  assign cell_cmd.loop_flag     = cmd_r.loop_flag;
  assign cell_cmd.reserved_flag = cmd_r.reserved_flag;
  assign cell_cmd.now           = seconds_r;
  assign cell_cmd.limit         = limit_r;

  // Write-back controls from the kind and the pick outcome.
  always_comb begin
    wr         = '0;
    wr.en      = (state_r == ST_APPLY);
    case (cmd_r.kind)
      KIND_PLAY: begin
        wr.refresh = (mode_r == MODE_HIT);
        wr.claim   = (mode_r == MODE_CLAIM_RSV) || (mode_r == MODE_CLAIM_FREE);
        wr.set_rsv = (mode_r == MODE_CLAIM_FREE);
      end
      KIND_PAUSE: wr.refresh = (mode_r == MODE_HIT);
      KIND_STOP:  wr.detach  = (mode_r == MODE_HIT);
      default:    wr.sweep   = sweep_now;
    endcase
  end

  // Row of slot cells.
  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    vsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rsv_init (i == 0),
      .cmd      (cell_cmd),
      .wr       (wr),
      .sel      (sel_r[i]),
      .st       (cell_st[i])
    );
    assign hit_v[i]   = cell_st[i].hit;
    assign resv_v[i]  = cell_st[i].reserved;
    assign att_v[i]   = cell_st[i].attached;
    assign loop_v[i]  = cell_st[i].looping;
    assign stale_v[i] = cell_st[i].stale;
  end

  // Capture cell status, then the picked slot.
  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      hit_r   <= hit_v;
      resv_r  <= resv_v;
      free_r  <= ~att_v;
      att_r   <= att_v;
      stale_r <= stale_v;
    end
    if (state_r == ST_PICK) begin
      sel_r  <= pick_oh;
      mode_r <= pick_mode;
    end
  end

  vsa_pick u_pick (
    .kind     (cmd_r.kind),
    .buf_zero (cmd_r.buffer_id[BUF_W-1:0] == '0),
    .hit      (hit_r),
    .resv     (resv_r),
    .free     (free_r),
    .onehot   (pick_oh),
    .mode     (pick_mode)
  );

  // Result word, built in the write-back cycle.
  always_comb begin
    out_nxt = '0;
    case (cmd_r.kind)
      KIND_PLAY: begin
        if (mode_r != MODE_MISS) begin
          out_nxt.slot  = 5'(sel_idx);
          out_nxt.out_x = cmd_r.pos_x;
          out_nxt.out_y = cmd_r.pos_y;
          out_nxt.out_z = cmd_r.pos_z;
          if (mode_r == MODE_HIT) begin
            out_nxt.action    = ACT_REPLAY;
            out_nxt.slot_loop = |(sel_r & loop_v);
          end else begin
            out_nxt.action    = ACT_CLAIM;
            out_nxt.slot_loop = cmd_r.loop_flag;
          end
        end
      end
      KIND_PAUSE: begin
        if (mode_r == MODE_HIT) begin
          out_nxt.action    = ACT_PAUSE;
          out_nxt.slot      = 5'(sel_idx);
          out_nxt.slot_loop = |(sel_r & loop_v);
        end
      end
      KIND_STOP: begin
        if (mode_r == MODE_HIT) begin
          out_nxt.action        = ACT_STOP;
          out_nxt.slot          = 5'(sel_idx);
          out_nxt.slot_loop     = |(sel_r & loop_v);
          out_nxt.released_mask = 32'(stop_rel[MASK_W-1:0]);
        end
      end
      default: begin
        if (sweep_now) begin
          out_nxt.action        = ACT_SWEEP;
          out_nxt.released_mask = 32'(sweep_rel[MASK_W-1:0]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_APPLY) begin
      out_r <= out_nxt;
    end
  end

  // The result strobe comes only once the sequencer is free again.
  `VSA_ASSERT_NOW(a_out_idle, clk, rst_n, out_valid, !busy)
  // The write-back cycle is always followed by the result strobe.
  `VSA_ASSERT_NEXT(a_apply_out, clk, rst_n, state_r == ST_APPLY, out_valid)
  // The picked slot is a single slot or none.
  `VSA_ASSERT_NOW(a_sel_onehot, clk, rst_n, state_r == ST_APPLY, $onehot0(sel_r))
  // Any pick other than a miss selects exactly one slot.
  `VSA_ASSERT_NOW(a_hit_sel, clk, rst_n, (state_r == ST_APPLY) && (mode_r != MODE_MISS),
    $onehot(sel_r))

endmodule
